FILE: rtl/core/fpa_pkg.sv
`default_nettype none
package fpa_pkg;

    localparam int FRAC_BITS = 16;
    // Dividend magnitude width: a 32-bit magnitude shifted left by FRAC_BITS.
    localparam int DIV_W = 32 + FRAC_BITS;

    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_SUB    = 4'd1;
    localparam logic [3:0] OP_MUL    = 4'd2;
    localparam logic [3:0] OP_DIV    = 4'd3;
    localparam logic [3:0] OP_IADD   = 4'd4;
    localparam logic [3:0] OP_ISUB   = 4'd5;
    localparam logic [3:0] OP_IMUL   = 4'd6;
    localparam logic [3:0] OP_IDIV   = 4'd7;
    localparam logic [3:0] OP_CMP    = 4'd8;
    localparam logic [3:0] OP_RESCL  = 4'd9;
    localparam logic [3:0] OP_INT    = 4'd10;
    localparam logic [3:0] OP_HALF   = 4'd11;
    localparam logic [3:0] OP_DOUBLE = 4'd12;
    localparam logic [3:0] OP_INC    = 4'd13;
    localparam logic [3:0] OP_DEC    = 4'd14;

    // Everything the final stage needs besides the quotient.
    typedef struct packed {
        logic        is_div;
        logic        neg;
        logic        dz;
        logic [31:0] result;
        logic        less;
        logic        equal;
        logic        ovf;
    } t_side;

    typedef struct packed {
        logic             valid;
        logic [31:0]      rem;
        logic [DIV_W-1:0] nq;
        logic [31:0]      dmag;
        t_side            side;
    } t_div;

endpackage
`default_nettype wire

FILE: rtl/core/fpa_front.sv
`default_nettype none
module fpa_front
    import fpa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [3:0]  i_req_type,
    input  wire logic [31:0] i_operand_a,
    input  wire logic [31:0] i_operand_b,
    input  wire logic [4:0]  i_source_frac_bits,
    output t_div             o_div
);

    logic               r_valid;
    logic [3:0]         r_op;
    logic [31:0]        r_a;
    logic [31:0]        r_b;
    logic [4:0]         r_sfb;
    logic signed [63:0] r_prod;
    logic signed [63:0] n_prod;

    assign n_prod = 64'($signed(i_operand_a) * $signed(i_operand_b));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_start;
        end
        r_op   <= i_req_type;
        r_a    <= i_operand_a;
        r_b    <= i_operand_b;
        r_sfb  <= i_source_frac_bits;
        r_prod <= n_prod;
    end

    logic signed [63:0] a_w;
    logic signed [63:0] b_w;
    logic signed [63:0] w;
    logic               check;
    logic               less;
    logic               equal;
    logic [31:0]        amag;
    logic [31:0]        bmag;
    logic [32:0]        rs_mag;
    logic [4:0]         rs_d;
    logic               fits;

    assign a_w  = {{32{r_a[31]}}, r_a};
    assign b_w  = {{32{r_b[31]}}, r_b};
    assign amag = r_a[31] ? (32'd0 - r_a) : r_a;
    assign bmag = r_b[31] ? (32'd0 - r_b) : r_b;
    assign rs_d = r_sfb - 5'(FRAC_BITS);
    assign rs_mag = {1'b0, amag} >> rs_d;

    always_comb begin
        w     = '0;
        check = 1'b1;
        less  = 1'b0;
        equal = 1'b0;
        unique case (r_op)
            OP_ADD:    w = a_w + b_w;
            OP_SUB:    w = a_w - b_w;
            OP_MUL:    w = r_prod >>> FRAC_BITS;
            OP_IADD:   w = a_w + (b_w <<< FRAC_BITS);
            OP_ISUB:   w = a_w - (b_w <<< FRAC_BITS);
            OP_IMUL:   w = r_prod;
            OP_DIV, OP_IDIV: w = '0;
            OP_CMP: begin
                less  = $signed(r_a) < $signed(r_b);
                equal = r_a == r_b;
            end
            OP_RESCL: begin
                if (r_sfb > 5'(FRAC_BITS)) begin
                    w = r_a[31] ? -$signed({31'd0, rs_mag}) : $signed({31'd0, rs_mag});
                end else begin
                    w = a_w <<< (5'(FRAC_BITS) - r_sfb);
                end
            end
            OP_INT:    w = a_w >>> FRAC_BITS;
            OP_HALF:   w = a_w >>> 1;
            OP_DOUBLE: w = a_w <<< 1;
            OP_INC:    w = a_w + 64'sd1;
            OP_DEC:    w = a_w - 64'sd1;
            default:   check = 1'b0;
        endcase
    end

    assign fits = (&w[63:31]) | ~(|w[63:31]);

    always_comb begin
        o_div.valid       = r_valid;
        o_div.rem         = '0;
        o_div.nq          = (r_op == OP_DIV) ? {amag, {FRAC_BITS{1'b0}}}
                                             : DIV_W'(amag);
        o_div.dmag        = bmag;
        o_div.side.is_div = (r_op == OP_DIV) || (r_op == OP_IDIV);
        o_div.side.neg    = r_a[31] ^ r_b[31];
        o_div.side.dz     = (r_b == 32'd0);
        o_div.side.result = w[31:0];
        o_div.side.less   = less;
        o_div.side.equal  = equal;
        o_div.side.ovf    = check & ~fits;
    end

endmodule
`default_nettype wire

FILE: rtl/core/fpa_div_stage.sv
`default_nettype none
module fpa_div_stage
    import fpa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_div i_d,
    output t_div      o_q
);

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    logic [32:0] trial;
    logic        ge;
    t_div        n_q;
    t_div        r_q;

    assign trial = {i_d.rem, i_d.nq[DIV_W-1]};
    assign ge    = trial >= {1'b0, i_d.dmag};

    always_comb begin
        n_q     = i_d;
        n_q.rem = ge ? 32'(trial - {1'b0, i_d.dmag}) : trial[31:0];
        n_q.nq  = {i_d.nq[DIV_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else begin
            r_q.valid <= n_q.valid;
        end
        r_q.rem  <= n_q.rem;
        r_q.nq   <= n_q.nq;
        r_q.dmag <= n_q.dmag;
        r_q.side <= n_q.side;
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

FILE: rtl/core/fixed_point_alu_core.sv
`default_nettype none
// Signed 32-bit fixed-point ALU, FRAC_BITS fraction bits, fully pipelined.
//
// Input channel: a request beat is taken at a rising edge with start high and
// busy low. busy is held low, so a new request may be issued in every cycle.
// Each request carries an opcode, two operands and a source fraction width.
//
// Output channel: every request yields exactly one result beat, in request
// order. o_valid is high for one cycle with the result fields alongside; the
// receiver must take it then, as there is no way to hold results back.
//
// The pipe has one input stage holding the operands and the 32x32 product,
// DIV_W restoring divider stages that retire one quotient bit each, and one
// output stage.
// The non-divide results are formed right after the input stage and ride
// along with the divider so that all opcodes share one latency.
// Throughput is one request per cycle.
//
// Reset clears only the valid bits in the pipe; requests in flight are lost.
module fixed_point_alu_core
    import fpa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  i_req_type,
    input  wire logic [31:0] i_operand_a,
    input  wire logic [31:0] i_operand_b,
    input  wire logic [4:0]  i_source_frac_bits,
    output logic             o_valid,
    output logic [31:0]      o_result,
    output logic             o_less,
    output logic             o_equal,
    output logic             o_overflow,
    output logic             o_div_zero
);

    // The pipe never stalls, so requests are always welcome.
    assign busy = 1'b0;

    t_div w_stage [0:DIV_W];

    fpa_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_req_type         (i_req_type),
        .i_operand_a        (i_operand_a),
        .i_operand_b        (i_operand_b),
        .i_source_frac_bits (i_source_frac_bits),
        .o_div              (w_stage[0])
    );

    for (genvar g = 0; g < DIV_W; g++) begin : g_div
        fpa_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (w_stage[g]),
            .o_q     (w_stage[g+1])
        );
    end

    // Final stage: for divides, give the quotient its sign, check that it fits 32 bits and flag a zero divisor.
    t_div             fin;
    logic [DIV_W:0]   qs;
    logic             q_fits;
    logic [31:0]      n_result;
    logic             n_less;
    logic             n_equal;
    logic             n_ovf;
    logic             n_dz;

    assign fin    = w_stage[DIV_W];
    assign qs     = fin.side.neg ? ((DIV_W+1)'(0) - {1'b0, fin.nq}) : {1'b0, fin.nq};
    assign q_fits = (&qs[DIV_W:31]) | ~(|qs[DIV_W:31]);

    always_comb begin
        n_result = fin.side.result;
        n_less   = fin.side.less;
        n_equal  = fin.side.equal;
        n_ovf    = fin.side.ovf;
        n_dz     = 1'b0;
        if (fin.side.is_div) begin
            n_less  = 1'b0;
            n_equal = 1'b0;
            if (fin.side.dz) begin
                n_result = '0;
                n_ovf    = 1'b0;
                n_dz     = 1'b1;
            end else begin
                n_result = qs[31:0];
                n_ovf    = ~q_fits;
            end
        end
    end

    logic r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= fin.valid;
        end
        o_result   <= n_result;
        o_less     <= n_less;
        o_equal    <= n_equal;
        o_overflow <= n_ovf;
        o_div_zero <= n_dz;
    end

    assign o_valid = r_valid;

endmodule
`default_nettype wire
